FILE: hdl/ascii_command_decoder_macros.svh
// Assertion macros shared by the checker of the ASCII command decoder.
`ifndef ASCII_COMMAND_DECODER_MACROS_SVH
`define ASCII_COMMAND_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acd_checker: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ACD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acd_checker: next-cycle check failed");

`endif

FILE: hdl/acd_pkg.sv
// Types, character codes and helper functions shared by the command decoder modules.
package acd_pkg;

    localparam int TEXT_MAX   = 30;
    // Queue depths must be powers of two so that the pointers wrap on their own.
    localparam int INQ_DEPTH  = 2;
    localparam int OUTQ_DEPTH = 4;

    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_R = 8'h52;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_LED,
        MODE_LEDOP,
        MODE_SWITCH,
        MODE_BUZZ,
        MODE_HEX,
        MODE_COOLER,
        MODE_MIRROR,
        MODE_TEXT,
        MODE_ERR
    } mode_t;

    typedef enum logic [1:0] {
        REPLY_NONE,
        REPLY_ACK,
        REPLY_ERR
    } reply_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LEDCLR,
        ACT_LEDSET,
        ACT_LEDREAD,
        ACT_SWREAD,
        ACT_BUZZ,
        ACT_HEX,
        ACT_COOLER,
        ACT_ANGLE,
        ACT_CHAR,
        ACT_TEXTEND,
        ACT_TEMP
    } action_t;

    // One input byte together with what the front end found out about it.
    typedef struct packed {
        logic [7:0] data;
        logic       last_byte;
        logic [3:0] leds;
        logic [3:0] sws;
        logic       blank;
        logic       dec;
        logic       hexl;
        logic [3:0] digit;
        logic       unit_ok;
        logic [1:0] unit;
        logic [1:0] led_op;
        mode_t      lead_mode;
        logic       lead_temp;
    } acd_class_t;

    typedef struct packed {
        reply_t      reply;
        action_t     action;
        logic [1:0]  target;
        logic [15:0] value;
        logic        is_on;
        logic        last;
    } acd_result_t;

    // Results of one byte, at most two, as written into the result queue.
    typedef struct packed {
        logic [1:0]  cnt;
        acd_result_t r0;
        acd_result_t r1;
    } acd_pair_t;

    function automatic acd_pair_t acd_put(acd_pair_t p, reply_t rp, action_t ac,
                                          logic [1:0] tg, logic [15:0] v, logic on);
        acd_result_t r;
        acd_pair_t   q;
        r.reply  = rp;
        r.action = ac;
        r.target = tg;
        r.value  = v;
        r.is_on  = on;
        r.last   = 1'b0;
        q = p;
        // A third result of the same byte is dropped.
        case (p.cnt)
            2'd0:
            begin
                q.r0  = r;
                q.cnt = 2'd1;
            end
            2'd1:
            begin
                q.r1  = r;
                q.cnt = 2'd2;
            end
            default:
            begin
                q = p;
            end
        endcase
        return q;
    endfunction

    function automatic action_t acd_num_action(mode_t m);
        action_t a;
        unique case (m)
            MODE_BUZZ:   a = ACT_BUZZ;
            MODE_HEX:    a = ACT_HEX;
            MODE_COOLER: a = ACT_COOLER;
            default:     a = ACT_ANGLE;
        endcase
        return a;
    endfunction

endpackage

FILE: hdl/acd_front.sv
// Front end: accepts command bytes, classifies them and queues them for the executor.
module acd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         cmd_byte,
    input  logic               buffer_end,
    input  logic [3:0]         led_levels,
    input  logic [3:0]         switch_levels,
    output acd_pkg::acd_class_t head,
    output logic               head_valid,
    input  logic               head_pop
);

    localparam int AW = $clog2(acd_pkg::INQ_DEPTH);
    localparam int CW = $clog2(acd_pkg::INQ_DEPTH + 1);

    acd_pkg::acd_class_t entry_reg [acd_pkg::INQ_DEPTH];
    acd_pkg::acd_class_t cls;
    logic [AW-1:0]       wp_reg, wp_next;
    logic [AW-1:0]       rp_reg, rp_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    always_comb
    begin
        cls.data      = cmd_byte;
        cls.last_byte = buffer_end;
        cls.leds      = led_levels;
        cls.sws       = switch_levels;
        cls.blank     = (cmd_byte == 8'h20) || (cmd_byte == 8'h09) || (cmd_byte == 8'h0D) ||
                        (cmd_byte == 8'h0A) || (cmd_byte == 8'h00);
        cls.dec       = (cmd_byte >= 8'h30) && (cmd_byte <= 8'h39);
        cls.hexl      = (cmd_byte >= 8'h41) && (cmd_byte <= 8'h46);
        // Letters A-F have low nibbles 1-6, so adding nine gives 10-15.
        cls.digit     = cls.dec ? cmd_byte[3:0] : cmd_byte[3:0] + 4'd9;
        cls.unit_ok   = (cmd_byte >= 8'h31) && (cmd_byte <= 8'h34);
        cls.unit      = cmd_byte[1:0] - 2'd1;
        unique case (cmd_byte)
            acd_pkg::CH_C: cls.led_op = 2'd1;
            acd_pkg::CH_S: cls.led_op = 2'd2;
            acd_pkg::CH_R: cls.led_op = 2'd3;
            default:       cls.led_op = 2'd0;
        endcase
        cls.lead_temp = 1'b0;
        unique case (cmd_byte)
            acd_pkg::CH_L: cls.lead_mode = acd_pkg::MODE_LED;
            acd_pkg::CH_S: cls.lead_mode = acd_pkg::MODE_SWITCH;
            acd_pkg::CH_B: cls.lead_mode = acd_pkg::MODE_BUZZ;
            acd_pkg::CH_D: cls.lead_mode = acd_pkg::MODE_HEX;
            acd_pkg::CH_P: cls.lead_mode = acd_pkg::MODE_TEXT;
            acd_pkg::CH_C: cls.lead_mode = acd_pkg::MODE_COOLER;
            acd_pkg::CH_M: cls.lead_mode = acd_pkg::MODE_MIRROR;
            acd_pkg::CH_T:
            begin
                cls.lead_mode = acd_pkg::MODE_IDLE;
                cls.lead_temp = 1'b1;
            end
            default:
            begin
                cls.lead_mode = cls.blank ? acd_pkg::MODE_IDLE : acd_pkg::MODE_ERR;
            end
        endcase
    end

    assign full       = (count_reg == CW'(acd_pkg::INQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rp_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_pop && head_valid;

    always_comb
    begin
        wp_next    = do_push ? wp_reg + AW'(1) : wp_reg;
        rp_next    = do_pop ? rp_reg + AW'(1) : rp_reg;
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/acd_exec.sv
// Back end: runs the command state machine on classified bytes and emits up to two results.
module acd_exec (
    input  logic                clk,
    input  logic                rst_n,
    input  acd_pkg::acd_class_t head,
    input  logic                head_valid,
    output logic                head_pop,
    input  logic                space,
    output acd_pkg::acd_pair_t  wr
);

    acd_pkg::mode_t     mode_reg, mode_next;
    logic [1:0]         lop_reg, lop_next;
    logic [15:0]        acc_reg, acc_next;
    logic [2:0]         dc_reg, dc_next;
    logic [4:0]         tl_reg, tl_next;
    acd_pkg::acd_pair_t p;
    acd_pkg::action_t   led_act;
    logic               hex;
    logic               dig_ok;
    logic [15:0]        acc_mul;
    logic [15:0]        acc_new;
    logic [2:0]         dc_new;
    logic [2:0]         maxd;
    logic [4:0]         tl_new;

    assign head_pop = head_valid && space;

    always_comb
    begin
        hex     = (mode_reg == acd_pkg::MODE_HEX) || (mode_reg == acd_pkg::MODE_COOLER);
        dig_ok  = head.dec || (hex && head.hexl);
        acc_mul = hex ? {acc_reg[11:0], 4'b0000}
                      : ({acc_reg[12:0], 3'b000} + {acc_reg[14:0], 1'b0});
        acc_new = acc_mul + {12'b0, head.digit};
        dc_new  = dc_reg + 3'd1;
        maxd    = hex ? 3'd4 : 3'd3;
        tl_new  = tl_reg + 5'd1;
        led_act = (lop_reg == 2'd0) ? acd_pkg::ACT_LEDCLR : acd_pkg::action_t'({2'b00, lop_reg});
    end

    always_comb
    begin
        mode_next = mode_reg;
        lop_next  = lop_reg;
        acc_next  = acc_reg;
        dc_next   = dc_reg;
        tl_next   = tl_reg;
        p         = '0;

        unique case (mode_reg) inside
            acd_pkg::MODE_LED:
            begin
                if (head.led_op != 2'd0)
                begin
                    mode_next = acd_pkg::MODE_LEDOP;
                    lop_next  = head.led_op;
                end
                else
                begin
                    mode_next = acd_pkg::MODE_ERR;
                end
            end
            acd_pkg::MODE_LEDOP:
            begin
                if (head.unit_ok)
                begin
                    p = acd_pkg::acd_put(p, acd_pkg::REPLY_ACK, led_act, head.unit, 16'd0,
                                         (led_act == acd_pkg::ACT_LEDREAD) && head.leds[head.unit]);
                    mode_next = acd_pkg::MODE_IDLE;
                end
                else
                begin
                    mode_next = acd_pkg::MODE_ERR;
                end
                lop_next = '0;
                acc_next = '0;
                dc_next  = '0;
                tl_next  = '0;
            end
            acd_pkg::MODE_SWITCH:
            begin
                if (head.unit_ok)
                begin
                    p = acd_pkg::acd_put(p, acd_pkg::REPLY_ACK, acd_pkg::ACT_SWREAD, head.unit,
                                         16'd0, head.sws[head.unit]);
                    mode_next = acd_pkg::MODE_IDLE;
                    lop_next  = '0;
                    acc_next  = '0;
                    dc_next   = '0;
                    tl_next   = '0;
                end
                else
                begin
                    mode_next = acd_pkg::MODE_ERR;
                end
            end
            acd_pkg::MODE_BUZZ, acd_pkg::MODE_HEX, acd_pkg::MODE_COOLER, acd_pkg::MODE_MIRROR:
            begin
                if (dig_ok)
                begin
                    acc_next = acc_new;
                    dc_next  = dc_new;
                    if (dc_new >= maxd)
                    begin
                        p = acd_pkg::acd_put(p, acd_pkg::REPLY_ACK,
                                             acd_pkg::acd_num_action(mode_reg), 2'd0, acc_new,
                                             1'b0);
                        mode_next = acd_pkg::MODE_IDLE;
                        lop_next  = '0;
                        acc_next  = '0;
                        dc_next   = '0;
                        tl_next   = '0;
                    end
                end
                else if (dc_reg == 3'd0)
                begin
                    if (head.blank)
                    begin
                        p = acd_pkg::acd_put(p, acd_pkg::REPLY_ERR, acd_pkg::ACT_NONE, 2'd0,
                                             16'd0, 1'b0);
                        mode_next = acd_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        mode_next = acd_pkg::MODE_ERR;
                    end
                    lop_next = '0;
                    acc_next = '0;
                    dc_next  = '0;
                    tl_next  = '0;
                end
                else
                begin
                    // The number ended early: acknowledge it, then treat the byte as a leader.
                    p = acd_pkg::acd_put(p, acd_pkg::REPLY_ACK,
                                         acd_pkg::acd_num_action(mode_reg), 2'd0, acc_reg, 1'b0);
                    mode_next = head.lead_mode;
                    lop_next  = '0;
                    acc_next  = '0;
                    dc_next   = '0;
                    tl_next   = '0;
                    if (head.lead_temp)
                    begin
                        p = acd_pkg::acd_put(p, acd_pkg::REPLY_NONE, acd_pkg::ACT_TEMP, 2'd0,
                                             16'd0, 1'b0);
                    end
                end
            end
            acd_pkg::MODE_TEXT:
            begin
                if (head.blank)
                begin
                    p = acd_pkg::acd_put(p, acd_pkg::REPLY_ACK, acd_pkg::ACT_TEXTEND, 2'd0,
                                         16'd0, 1'b0);
                    mode_next = acd_pkg::MODE_IDLE;
                    lop_next  = '0;
                    acc_next  = '0;
                    dc_next   = '0;
                    tl_next   = '0;
                end
                else
                begin
                    p = acd_pkg::acd_put(p, acd_pkg::REPLY_NONE, acd_pkg::ACT_CHAR, 2'd0,
                                         {8'h00, head.data}, 1'b0);
                    tl_next = tl_new;
                    if (tl_new >= 5'(acd_pkg::TEXT_MAX))
                    begin
                        p = acd_pkg::acd_put(p, acd_pkg::REPLY_ACK, acd_pkg::ACT_TEXTEND, 2'd0,
                                             16'd0, 1'b0);
                        mode_next = acd_pkg::MODE_IDLE;
                        lop_next  = '0;
                        acc_next  = '0;
                        dc_next   = '0;
                        tl_next   = '0;
                    end
                end
            end
            acd_pkg::MODE_ERR:
            begin
                if (head.blank)
                begin
                    p = acd_pkg::acd_put(p, acd_pkg::REPLY_ERR, acd_pkg::ACT_NONE, 2'd0,
                                         16'd0, 1'b0);
                    mode_next = acd_pkg::MODE_IDLE;
                    lop_next  = '0;
                    acc_next  = '0;
                    dc_next   = '0;
                    tl_next   = '0;
                end
            end
            default:
            begin
                mode_next = head.lead_mode;
                lop_next  = '0;
                acc_next  = '0;
                dc_next   = '0;
                tl_next   = '0;
                if (head.lead_temp)
                begin
                    p = acd_pkg::acd_put(p, acd_pkg::REPLY_NONE, acd_pkg::ACT_TEMP, 2'd0,
                                         16'd0, 1'b0);
                end
            end
        endcase

        // At the end of a buffer, whatever is still open is closed out.
        if (head.last_byte)
        begin
            unique case (mode_next) inside
                acd_pkg::MODE_LED, acd_pkg::MODE_LEDOP, acd_pkg::MODE_SWITCH, acd_pkg::MODE_ERR:
                begin
                    p = acd_pkg::acd_put(p, acd_pkg::REPLY_ERR, acd_pkg::ACT_NONE, 2'd0,
                                         16'd0, 1'b0);
                end
                acd_pkg::MODE_BUZZ, acd_pkg::MODE_HEX, acd_pkg::MODE_COOLER,
                acd_pkg::MODE_MIRROR:
                begin
                    if (dc_next != 3'd0)
                    begin
                        p = acd_pkg::acd_put(p, acd_pkg::REPLY_ACK,
                                             acd_pkg::acd_num_action(mode_next), 2'd0, acc_next,
                                             1'b0);
                    end
                    else
                    begin
                        p = acd_pkg::acd_put(p, acd_pkg::REPLY_ERR, acd_pkg::ACT_NONE, 2'd0,
                                             16'd0, 1'b0);
                    end
                end
                acd_pkg::MODE_TEXT:
                begin
                    p = acd_pkg::acd_put(p, acd_pkg::REPLY_ACK, acd_pkg::ACT_TEXTEND, 2'd0,
                                         16'd0, 1'b0);
                end
                default:
                begin
                    p = p;
                end
            endcase
            mode_next = acd_pkg::MODE_IDLE;
            lop_next  = '0;
            acc_next  = '0;
            dc_next   = '0;
            tl_next   = '0;
        end

        if (p.cnt == 2'd1)
        begin
            p.r0.last = 1'b1;
        end
        else if (p.cnt == 2'd2)
        begin
            p.r1.last = 1'b1;
        end

        wr = p;
        if (!head_pop)
        begin
            wr.cnt = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= acd_pkg::MODE_IDLE;
            lop_reg  <= '0;
            acc_reg  <= '0;
            dc_reg   <= '0;
            tl_reg   <= '0;
        end
        else if (head_pop)
        begin
            mode_reg <= mode_next;
            lop_reg  <= lop_next;
            acc_reg  <= acc_next;
            dc_reg   <= dc_next;
            tl_reg   <= tl_next;
        end
    end

endmodule

FILE: hdl/acd_outq.sv
// Result queue: takes up to two results per cycle and hands them out one at a time.
module acd_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  acd_pkg::acd_pair_t  wr,
    output logic                space,
    output logic                empty,
    input  logic                pop,
    output acd_pkg::acd_result_t head
);

    localparam int AW = $clog2(acd_pkg::OUTQ_DEPTH);
    localparam int CW = $clog2(acd_pkg::OUTQ_DEPTH + 1);

    acd_pkg::acd_result_t entry_reg [acd_pkg::OUTQ_DEPTH];
    logic [AW-1:0]        wp_reg, wp_next;
    logic [AW-1:0]        rp_reg, rp_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 do_pop;

    assign empty  = (count_reg == '0);
    // Room for a full pair, whether or not a result leaves this cycle.
    assign space  = (count_reg <= CW'(acd_pkg::OUTQ_DEPTH - 2));
    assign head   = entry_reg[rp_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wp_next    = wp_reg + AW'(wr.cnt);
        rp_next    = do_pop ? rp_reg + AW'(1) : rp_reg;
        count_next = count_reg + CW'(wr.cnt) - CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr.cnt != 2'd0)
        begin
            entry_reg[wp_reg] <= wr.r0;
        end
        if (wr.cnt == 2'd2)
        begin
            entry_reg[wp_reg + AW'(1)] <= wr.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/ascii_command_decoder.sv
// Top level of the ASCII command decoder: front end, executor and result queue.
//
//   Channel   Handshake         Payload
//   input     push / full       cmd_byte, buffer_end, led_levels, switch_levels
//   result    empty / pop       reply, action, target, value, is_on, last_of_run
//
// One byte is accepted per cycle while the input queue is not full. A byte
// enters a two-entry input queue and is decoded by the command state machine
// once it is at the head and the result queue has room; its results are then
// registered into the result queue and show on the result ports at its head.
// Bytes that give two results run at the pop rate of one result per cycle.
// The executor takes a byte only when the result queue has room for two results.
// Reset empties both queues and puts the decoder in idle; no clearing pass.
module ascii_command_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  cmd_byte,
    input  logic        buffer_end,
    input  logic [3:0]  led_levels,
    input  logic [3:0]  switch_levels,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  reply,
    output logic [3:0]  action,
    output logic [1:0]  target,
    output logic [15:0] value,
    output logic        is_on,
    output logic        last_of_run
);

    acd_pkg::acd_class_t  head;
    logic                 head_valid;
    logic                 head_pop;
    logic                 space;
    acd_pkg::acd_pair_t   wr;
    acd_pkg::acd_result_t res;

    acd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd_byte      (cmd_byte),
        .buffer_end    (buffer_end),
        .led_levels    (led_levels),
        .switch_levels (switch_levels),
        .head          (head),
        .head_valid    (head_valid),
        .head_pop      (head_pop)
    );

    acd_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .space      (space),
        .wr         (wr)
    );

    acd_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .space (space),
        .empty (empty),
        .pop   (pop),
        .head  (res)
    );

    assign reply       = res.reply;
    assign action      = res.action;
    assign target      = res.target;
    assign value       = res.value;
    assign is_on       = res.is_on;
    assign last_of_run = res.last;

endmodule

FILE: hdl/acd_checker.sv
// Port-level checks of the command decoder result channel, bound to the top level.
`include "ascii_command_decoder_macros.svh"

module acd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  reply,
    input logic [3:0]  action,
    input logic [1:0]  target,
    input logic [15:0] value,
    input logic        is_on
);

    // A waiting result transaction stays put until it is taken.
    `ACD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(action) && $stable(value))

    `ACD_ASSERT_IMPLY(a_temp, !empty && action == acd_pkg::ACT_TEMP, reply == acd_pkg::REPLY_NONE && target == 2'd0 && value == 16'd0)

    `ACD_ASSERT_IMPLY(a_char, !empty && action == acd_pkg::ACT_CHAR, reply == acd_pkg::REPLY_NONE && value[15:8] == 8'h00)

    `ACD_ASSERT_IMPLY(a_is_on, !empty && is_on, action == acd_pkg::ACT_LEDREAD || action == acd_pkg::ACT_SWREAD)

    `ACD_ASSERT_IMPLY(a_err, !empty && reply == acd_pkg::REPLY_ERR, action == acd_pkg::ACT_NONE && value == 16'd0 && target == 2'd0)

endmodule

bind ascii_command_decoder acd_checker u_acd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .reply  (reply),
    .action (action),
    .target (target),
    .value  (value),
    .is_on  (is_on)
);
